FILE: hdl/epsm_pkg.sv
// ----------------------------------------------------------------------------
// epsm_pkg: shared types and constants of the encoder pulse speed meter
// Field widths, register map, reset values and sizes of the bit-serial units.
// ----------------------------------------------------------------------------
`default_nettype none

package epsm_pkg;

    // Field widths.
    localparam int MS_W    = 16;
    localparam int CIRC_W  = 12;
    localparam int SLOT_W  = 8;
    localparam int ITEM_W  = 8;
    localparam int SPEED_W = 16;

    // Speed is reported in hundredths of cm/s from millimetres per millisecond.
    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] CENTI_SCALE = 14'd10000;

    // Derived widths of the arithmetic units.
    localparam int K_W   = SCALE_W + CIRC_W;  // circumference * scale
    localparam int DEN_W = MS_W + SLOT_W;     // slot count * dt

    localparam int PULSE_COUNT_BITS_DEF = 32;

    // Register map.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_INTERVAL = 2'd0,
        REG_TIMEOUT  = 2'd1,
        REG_CIRC     = 2'd2,
        REG_SLOTS    = 2'd3
    } reg_idx_t;

    localparam logic [MS_W-1:0]   INTERVAL_RST = 16'd50;
    localparam logic [MS_W-1:0]   TIMEOUT_RST  = 16'd500;
    localparam logic [CIRC_W-1:0] CIRC_RST     = 12'd100;
    localparam logic [SLOT_W-1:0] SLOTS_RST    = 8'd20;

    // One-hot sequencer states of the top level.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_KMUL = 5'b00010,
        S_NMUL = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

endpackage : epsm_pkg

`default_nettype wire

FILE: hdl/epsm_smul.sv
// ----------------------------------------------------------------------------
// epsm_smul: bit-serial unsigned multiplier
// Shift-add over the bits of b, least significant first, one bit per cycle.
// The product stays on prod after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module epsm_smul #(
    parameter int A_W = 14,
    parameter int B_W = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic                    done,
    output logic [A_W+B_W-1:0]      prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [A_W-1:0]   hi_reg;
    logic [B_W-1:0]   lo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W:0]     sum;

    // The low product bits move into the multiplier register as its bits retire.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(A_W+1){1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[A_W:1];
            lo_reg <= {sum[0], lo_reg[B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule : epsm_smul

`default_nettype wire

FILE: hdl/epsm_sdiv.sv
// ----------------------------------------------------------------------------
// epsm_sdiv: bit-serial restoring divider with saturating quotient
// One quotient bit per cycle, numerator most significant bit first. A quotient
// that does not fit in Q_W bits reads as all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module epsm_sdiv #(
    parameter int N_W = 58,
    parameter int D_W = 24,
    parameter int Q_W = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [N_W-1:0] num,
    input  wire logic [D_W-1:0] den,
    output logic                done,
    output logic [Q_W-1:0]      quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   n_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   r_reg;
    logic [Q_W-1:0]   q_reg;
    logic             sat_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     shifted;
    logic [D_W+1:0]   diff;
    logic             qbit;

    assign shifted = {r_reg, n_reg[N_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign qbit    = ~diff[D_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below the divisor, so it fits in D_W bits.
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= num;
            den_reg <= den;
            r_reg   <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (busy_reg) begin
            n_reg   <= {n_reg[N_W-2:0], 1'b0};
            r_reg   <= qbit ? diff[D_W-1:0] : shifted[D_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], qbit};
            sat_reg <= sat_reg | q_reg[Q_W-1];
        end
    end

    assign done = done_reg;
    assign quo  = sat_reg ? {Q_W{1'b1}} : q_reg;

endmodule : epsm_sdiv

`default_nettype wire

FILE: hdl/encoder_pulse_speed_meter_core.sv
// ----------------------------------------------------------------------------
// encoder_pulse_speed_meter_core: belt speed from encoder pulse counts
// Keeps the pulse total and time since the last speed computation, and works
// out delta * circumference * 10000 / (slots * dt) with bit-serial units.
//
//   Channel  Direction  Payload                                   Handshake
//   s_       in         elapsed_ms, new_pulses                    valid/ready
//   m_       out        speed_centi_cm_s, total_pulses, computed  valid/ready
//   apb      in         interval, timeout, circumference, slots   psel/penable
//
// A transaction that does not start a computation loads the result directly.
// One that does runs the circumference scaling, the pulse multiplier and the
// divider in turn, each one bit per cycle.
// Reset is synchronous and active low; it loads the register defaults and
// clears all counters. A stalled result holds off the next input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_pulse_speed_meter_core #(
    parameter int PULSE_COUNT_BITS = epsm_pkg::PULSE_COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [epsm_pkg::ITEM_W-1:0]       s_elapsed_ms,
    input  wire logic [epsm_pkg::ITEM_W-1:0]       s_new_pulses,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [epsm_pkg::SPEED_W-1:0]           m_speed_centi_cm_s,
    output logic [PULSE_COUNT_BITS-1:0]            m_total_pulses,
    output logic                                   m_computed,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [epsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [epsm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [epsm_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    import epsm_pkg::*;

    localparam int P     = PULSE_COUNT_BITS;
    localparam int NUM_W = K_W + P;

    // Configuration registers.
    logic [MS_W-1:0]   interval_reg;
    logic [MS_W-1:0]   timeout_reg;
    logic [CIRC_W-1:0] circ_reg;
    logic [SLOT_W-1:0] slots_reg;
    logic              cfg_write;

    // Measurement state.
    state_t            state_reg,       state_next;
    logic [P-1:0]      pulse_total_reg, pulse_total_next;
    logic [P-1:0]      at_calc_reg,     at_calc_next;
    logic [MS_W-1:0]   ms_reg,          ms_next;
    logic [SPEED_W-1:0] speed_reg,      speed_next;
    logic [P-1:0]      delta_reg,       delta_next;
    logic              den_ok_reg;

    // Output register.
    logic               m_valid_reg;
    logic [SPEED_W-1:0] m_speed_reg;
    logic [P-1:0]       m_total_reg;
    logic               m_computed_reg;
    logic               out_load;
    logic               out_computed;

    logic              accept;
    logic [MS_W:0]     ms_sum;
    logic [MS_W-1:0]   ms_sat;
    logic [P-1:0]      total_sum;
    logic              due;
    logic              slow;

    logic              k_start,  n_start,  d_start;
    logic              k_done,   den_done, n_done, d_done;
    logic [K_W-1:0]    k_prod;
    logic [DEN_W-1:0]  den_prod;
    logic [NUM_W-1:0]  num_prod;
    logic [SPEED_W-1:0] quo;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RST;
            timeout_reg  <= TIMEOUT_RST;
            circ_reg     <= CIRC_RST;
            slots_reg    <= SLOTS_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_INTERVAL: interval_reg <= pwdata[MS_W-1:0];
                REG_TIMEOUT:  timeout_reg  <= pwdata[MS_W-1:0];
                REG_CIRC:     circ_reg     <= pwdata[CIRC_W-1:0];
                REG_SLOTS:    slots_reg    <= pwdata[SLOT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_INTERVAL: prdata = APB_DATA_W'(interval_reg);
            REG_TIMEOUT:  prdata = APB_DATA_W'(timeout_reg);
            REG_CIRC:     prdata = APB_DATA_W'(circ_reg);
            REG_SLOTS:    prdata = APB_DATA_W'(slots_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------
    epsm_smul #(.A_W(SCALE_W), .B_W(CIRC_W)) u_kmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (k_start),
        .a       (CENTI_SCALE),
        .b       (circ_reg),
        .done    (k_done),
        .prod    (k_prod)
    );

    epsm_smul #(.A_W(MS_W), .B_W(SLOT_W)) u_denmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (k_start),
        .a       (ms_sat),
        .b       (slots_reg),
        .done    (den_done),
        .prod    (den_prod)
    );

    epsm_smul #(.A_W(K_W), .B_W(P)) u_nmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (n_start),
        .a       (k_prod),
        .b       (delta_reg),
        .done    (n_done),
        .prod    (num_prod)
    );

    epsm_sdiv #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(SPEED_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (d_start),
        .num     (num_prod),
        .den     (den_prod),
        .done    (d_done),
        .quo     (quo)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid & s_ready;

    assign ms_sum    = {1'b0, ms_reg} + (MS_W+1)'(s_elapsed_ms);
    assign ms_sat    = ms_sum[MS_W] ? {MS_W{1'b1}} : ms_sum[MS_W-1:0];
    assign total_sum = pulse_total_reg + P'(s_new_pulses);
    assign due       = ms_sat >= interval_reg;
    assign slow      = ms_sat >= timeout_reg;

    always_comb begin
        state_next       = state_reg;
        pulse_total_next = pulse_total_reg;
        at_calc_next     = at_calc_reg;
        ms_next          = ms_reg;
        speed_next       = speed_reg;
        delta_next       = delta_reg;
        out_load         = 1'b0;
        out_computed     = 1'b0;
        k_start          = 1'b0;
        n_start          = 1'b0;
        d_start          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pulse_total_next = total_sum;
                    if (due) begin
                        at_calc_next = total_sum;
                        delta_next   = total_sum - at_calc_reg;
                        ms_next      = '0;
                        if (slow) begin
                            // Interval too long for a meaningful speed.
                            speed_next   = '0;
                            out_load     = 1'b1;
                            out_computed = 1'b1;
                        end else begin
                            k_start    = 1'b1;
                            state_next = S_KMUL;
                        end
                    end else begin
                        ms_next = ms_sat;
                        // No pulses since the last computation for too long.
                        if (total_sum == at_calc_reg && slow) begin
                            speed_next = '0;
                        end
                        out_load = 1'b1;
                    end
                end
            end
            S_KMUL: begin
                // The divisor product is shorter and is ready by now as well.
                if (k_done && den_ok_reg) begin
                    n_start    = 1'b1;
                    state_next = S_NMUL;
                end
            end
            S_NMUL: begin
                if (n_done) begin
                    if (den_prod == '0) begin
                        speed_next = (num_prod != '0) ? {SPEED_W{1'b1}} : '0;
                        state_next = S_OUT;
                    end else begin
                        d_start    = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (d_done) begin
                    speed_next = quo;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    out_computed = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            pulse_total_reg <= '0;
            at_calc_reg     <= '0;
            ms_reg          <= '0;
            speed_reg       <= '0;
            m_valid_reg     <= 1'b0;
            den_ok_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pulse_total_reg <= pulse_total_next;
            at_calc_reg     <= at_calc_next;
            ms_reg          <= ms_next;
            speed_reg       <= speed_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (k_start) begin
                den_ok_reg <= 1'b0;
            end else if (den_done) begin
                den_ok_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg <= delta_next;
        if (out_load) begin
            m_speed_reg    <= speed_next;
            m_total_reg    <= at_calc_next;
            m_computed_reg <= out_computed;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_speed_centi_cm_s = m_speed_reg;
    assign m_total_pulses     = m_total_reg;
    assign m_computed         = m_computed_reg;

endmodule : encoder_pulse_speed_meter_core

`default_nettype wire
